[hw/rtl/cdda_pkg.sv]
// Shared types and constants for the calendar date day adder.
// Holds field widths, register codes, controller state encoding, the
// command/status structs and the month length function. No dependencies.
package cdda_pkg;

    localparam int YEAR_W     = 16;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 16'hFFFF;
    localparam logic [YEAR_W-1:0]  YEAR_MIN      = 16'd1;
    localparam logic [YEAR_W-1:0]  START_YEAR_RST = 16'd2024;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC  = 5'd31;

    // Divisibility by 25 is tested with the multiplicative inverse of 25
    // modulo 2^16: n is a multiple of 25 exactly when n * inverse, kept to
    // 16 bits, does not exceed (2^16 - 1) / 25.
    localparam logic [YEAR_W-1:0] INV25       = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_YEAR  = 2'd0,
        REG_START_MONTH = 2'd1,
        REG_START_DAY   = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PREP   = 4'b0010,
        ST_STEP   = 4'b0100,
        ST_FINISH = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        logic load;    // take a request into the working registers
        logic step;    // remove one month if the day count exceeds it
        logic finish;  // move the working date to the result registers
    } dp_cmd_t;

    typedef struct packed {
        logic step_end;  // the day fits in the month, or the year saturated
    } dp_status_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] days;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
            4'd2:                                       days = leap ? 5'd29 : 5'd28;
            default:                                    days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

[hw/rtl/cdda_ifs.sv]
// Handshake channel interfaces for the calendar date day adder.
// Request, result and configuration channels; widths from cdda_pkg.
interface cdda_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [cdda_pkg::COUNT_W-1:0] days_to_add;

    modport source (output valid, output op, output days_to_add, input ready);
    modport sink   (input valid, input op, input days_to_add, output ready);
endinterface

interface cdda_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cdda_pkg::YEAR_W-1:0]  result_year;
    logic [cdda_pkg::MONTH_W-1:0] result_month;
    logic [cdda_pkg::DAY_W-1:0]   result_day;
    logic                         year_overflow;

    modport source (output valid, output result_year, output result_month,
                    output result_day, output year_overflow, input ready);
    modport sink   (input valid, input result_year, input result_month,
                    input result_day, input year_overflow, output ready);
endinterface

interface cdda_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cdda_pkg::CFG_IDX_W-1:0]  index;
    logic [cdda_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/calendar_date_day_adder_unit.sv]
// Top level of the calendar date day adder.
// Instantiates cdda_ctrl and cdda_datapath; uses cdda_pkg and the channel
// interfaces of cdda_ifs.sv.
//
// The unit keeps a current Gregorian date and adds a day count to it for each
// request on the req channel (op, days_to_add). Each request yields exactly one
// result on the rsp channel: the new year, month, day and a year_overflow flag
// that marks saturation at December 31 of year 65535. With op set the result
// also becomes the current date.
//
// The cfg channel writes start_year (index 0), start_month (1) and start_day
// (2); any of these writes reloads the current date from all three start
// registers, with zero fields raised to 1 and a month above 12 set to 12. It
// is always ready and is meant to be used only while no request is in flight.
//
// A request passes from acceptance through PREP, then STEP, where the
// month-stepping loop in the datapath removes one month per cycle until the
// day fits or the year saturates, then FINISH, which fills the result
// registers. One request is worked on at a time. The result sits in
// its own output register, so the next request is accepted while an earlier
// result still waits; a stalled receiver holds back only the following
// result. Reset restores start and current date to January 1, 2024.
module calendar_date_day_adder_unit #(
    parameter int DAY_COUNT_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    cdda_req_if.sink   req,
    cdda_rsp_if.source rsp,
    cdda_cfg_if.sink   cfg
);

    cdda_pkg::dp_cmd_t    cmd;
    cdda_pkg::dp_status_t status;
    logic                 cfg_we;

    // Configuration writes go straight into registers; the channel never stalls.
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    cdda_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    cdda_datapath #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_op     (req.op),
        .in_days   (req.days_to_add),
        .cmd       (cmd),
        .status    (status),
        .res_year  (rsp.result_year),
        .res_month (rsp.result_month),
        .res_day   (rsp.result_day),
        .res_ovf   (rsp.year_overflow)
    );

endmodule

[hw/rtl/cdda_ctrl.sv]
// Controller state machine of the calendar date day adder.
// Sequences load, month stepping and result handoff; uses cdda_pkg.
module cdda_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cdda_pkg::dp_cmd_t    cmd,
    input  cdda_pkg::dp_status_t status
);

    cdda_pkg::ctrl_state_t state_reg;
    cdda_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  in_fire;
    logic                  finish_fire;

    assign in_ready    = (state_reg == cdda_pkg::ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    // The result slot is free when empty or being emptied this cycle.
    assign finish_fire = (state_reg == cdda_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdda_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = cdda_pkg::ST_PREP;
                end
            end
            cdda_pkg::ST_PREP:
            begin
                state_next = cdda_pkg::ST_STEP;
            end
            cdda_pkg::ST_STEP:
            begin
                if (status.step_end)
                begin
                    state_next = cdda_pkg::ST_FINISH;
                end
            end
            cdda_pkg::ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = cdda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cmd.load   = in_fire;
        cmd.step   = (state_reg == cdda_pkg::ST_STEP);
        cmd.finish = finish_fire;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == cdda_pkg::ST_PREP)
        else $error("accepted request did not start the load cycle");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cdda_pkg::ST_FINISH))
        else $error("result appeared without a finish cycle");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdda_pkg::ST_FINISH) && out_valid_reg && !out_ready
        |=> state_reg == cdda_pkg::ST_FINISH)
        else $error("finish overwrote a result not yet taken");

endmodule

[hw/rtl/cdda_datapath.sv]
// Datapath of the calendar date day adder: start and current date registers,
// the working date with its day accumulator, leap-year logic and result
// registers. Uses cdda_pkg; driven by cdda_ctrl.
module cdda_datapath #(
    parameter int DAY_COUNT_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cdda_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdda_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_op,
    input  logic [cdda_pkg::COUNT_W-1:0]      in_days,
    input  cdda_pkg::dp_cmd_t                 cmd,
    output cdda_pkg::dp_status_t              status,
    output logic [cdda_pkg::YEAR_W-1:0]       res_year,
    output logic [cdda_pkg::MONTH_W-1:0]      res_month,
    output logic [cdda_pkg::DAY_W-1:0]        res_day,
    output logic                              res_ovf
);

    // Only the low DAY_COUNT_BITS of the 16-bit count take part.
    localparam int CNT_W = (DAY_COUNT_BITS < cdda_pkg::COUNT_W) ? DAY_COUNT_BITS
                                                                : cdda_pkg::COUNT_W;
    localparam int ACC_W = CNT_W + 1;

    localparam logic [cdda_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST = cdda_pkg::REG_START_DAY;

    logic [cdda_pkg::YEAR_W-1:0]  start_year_reg,  start_year_next;
    logic [cdda_pkg::MONTH_W-1:0] start_month_reg, start_month_next;
    logic [cdda_pkg::DAY_W-1:0]   start_day_reg,   start_day_next;

    logic [cdda_pkg::YEAR_W-1:0]  cur_year_reg,  cur_year_next;
    logic [cdda_pkg::MONTH_W-1:0] cur_month_reg, cur_month_next;
    logic [cdda_pkg::DAY_W-1:0]   cur_day_reg,   cur_day_next;

    logic [cdda_pkg::YEAR_W-1:0]  work_year_reg,  work_year_next;
    logic [cdda_pkg::MONTH_W-1:0] work_month_reg, work_month_next;
    logic [ACC_W-1:0]             work_acc_reg,   work_acc_next;
    logic                         work_ovf_reg,   work_ovf_next;
    logic                         work_op_reg,    work_op_next;
    logic                         leap_reg;

    logic [cdda_pkg::YEAR_W-1:0]  res_year_reg;
    logic [cdda_pkg::MONTH_W-1:0] res_month_reg;
    logic [cdda_pkg::DAY_W-1:0]   res_day_reg;
    logic                         res_ovf_reg;

    logic [2*cdda_pkg::YEAR_W-1:0] inv_prod;
    logic                          div25;
    logic                          leap_next;
    logic [cdda_pkg::DAY_W-1:0]    month_len;
    logic                          fits;
    logic                          sat;

    // Leap flag is the registered leap test of the working year, updated in
    // the next cycle. The year only moves into January, which never needs
    // the flag, so it is always settled by the time February is stepped.
    assign inv_prod  = 32'(work_year_reg) * 32'(cdda_pkg::INV25);
    assign div25     = (inv_prod[cdda_pkg::YEAR_W-1:0] <= cdda_pkg::DIV25_LIMIT);
    assign leap_next = div25 ? (work_year_reg[3:0] == 4'd0) : (work_year_reg[1:0] == 2'd0);

    assign month_len = cdda_pkg::month_days(work_month_reg, leap_reg);
    assign fits      = (work_acc_reg <= ACC_W'(month_len));
    assign sat       = !fits && (work_month_reg == cdda_pkg::MONTH_DEC)
                       && (work_year_reg == cdda_pkg::YEAR_MAX);

    assign status.step_end = fits || sat;

    // Start registers; any write to index 0, 1 or 2 reloads the current date from all three.
    always_comb
    begin
        start_year_next  = start_year_reg;
        start_month_next = start_month_reg;
        start_day_next   = start_day_reg;
        if (cfg_we)
        begin
            unique case (cdda_pkg::cfg_reg_t'(cfg_index))
                cdda_pkg::REG_START_YEAR:  start_year_next  = cfg_data;
                cdda_pkg::REG_START_MONTH: start_month_next = cfg_data[cdda_pkg::MONTH_W-1:0];
                cdda_pkg::REG_START_DAY:   start_day_next   = cfg_data[cdda_pkg::DAY_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        if (cfg_we && (cfg_index <= CFG_IDX_LAST))
        begin
            cur_year_next = (start_year_next == '0) ? cdda_pkg::YEAR_MIN : start_year_next;
            priority if (start_month_next == '0)
            begin
                cur_month_next = cdda_pkg::MONTH_JAN;
            end
            else if (start_month_next > cdda_pkg::MONTH_DEC)
            begin
                cur_month_next = cdda_pkg::MONTH_DEC;
            end
            else
            begin
                cur_month_next = start_month_next;
            end
            cur_day_next = (start_day_next == '0) ? cdda_pkg::DAY_FIRST : start_day_next;
        end
        else if (cmd.finish && work_op_reg)
        begin
            cur_year_next  = work_year_reg;
            cur_month_next = work_month_reg;
            cur_day_next   = work_acc_reg[cdda_pkg::DAY_W-1:0];
        end
    end

    always_comb
    begin
        work_year_next  = work_year_reg;
        work_month_next = work_month_reg;
        work_acc_next   = work_acc_reg;
        work_ovf_next   = work_ovf_reg;
        work_op_next    = work_op_reg;
        if (cmd.load)
        begin
            work_year_next  = cur_year_reg;
            work_month_next = cur_month_reg;
            work_acc_next   = ACC_W'(cur_day_reg) + ACC_W'(in_days[CNT_W-1:0]);
            work_ovf_next   = 1'b0;
            work_op_next    = in_op;
        end
        else if (cmd.step && !fits)
        begin
            if (sat)
            begin
                // Past the last representable year: pin to its final day.
                work_acc_next = ACC_W'(cdda_pkg::DAY_LAST_DEC);
                work_ovf_next = 1'b1;
            end
            else
            begin
                work_acc_next = work_acc_reg - ACC_W'(month_len);
                if (work_month_reg == cdda_pkg::MONTH_DEC)
                begin
                    work_month_next = cdda_pkg::MONTH_JAN;
                    work_year_next  = work_year_reg + 16'd1;
                end
                else
                begin
                    work_month_next = work_month_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_year_reg  <= cdda_pkg::START_YEAR_RST;
            start_month_reg <= cdda_pkg::MONTH_JAN;
            start_day_reg   <= cdda_pkg::DAY_FIRST;
            cur_year_reg    <= cdda_pkg::START_YEAR_RST;
            cur_month_reg   <= cdda_pkg::MONTH_JAN;
            cur_day_reg     <= cdda_pkg::DAY_FIRST;
        end
        else
        begin
            start_year_reg  <= start_year_next;
            start_month_reg <= start_month_next;
            start_day_reg   <= start_day_next;
            cur_year_reg    <= cur_year_next;
            cur_month_reg   <= cur_month_next;
            cur_day_reg     <= cur_day_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_year_reg  <= work_year_next;
        work_month_reg <= work_month_next;
        work_acc_reg   <= work_acc_next;
        work_ovf_reg   <= work_ovf_next;
        work_op_reg    <= work_op_next;
        leap_reg       <= leap_next;
        if (cmd.finish)
        begin
            res_year_reg  <= work_year_reg;
            res_month_reg <= work_month_reg;
            res_day_reg   <= work_acc_reg[cdda_pkg::DAY_W-1:0];
            res_ovf_reg   <= work_ovf_reg;
        end
    end

    assign res_year  = res_year_reg;
    assign res_month = res_month_reg;
    assign res_day   = res_day_reg;
    assign res_ovf   = res_ovf_reg;

    a_month_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (work_month_reg >= cdda_pkg::MONTH_JAN)
                     && (work_month_reg <= cdda_pkg::MONTH_DEC))
        else $error("working month left the calendar range");

    a_day_fits_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> work_acc_reg <= ACC_W'(cdda_pkg::DAY_LAST_DEC))
        else $error("finished with a day count larger than any month");

    a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && work_ovf_reg |-> (work_year_reg == cdda_pkg::YEAR_MAX)
                                       && (work_month_reg == cdda_pkg::MONTH_DEC))
        else $error("overflow result is not the last month of the last year");

endmodule
